@@ src/rmd_pkg.sv @@
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types and constants of the record marker deframer.
// ----------------------------------------------------------------------------
package rmd_pkg;

  // Register map, as word indexes on the configuration port
  localparam logic REG_RECORD_LENGTH  = 1'b0;
  localparam logic REG_PARTICLE_COUNT = 1'b1;

  localparam int unsigned PADDR_W = 3;

  // Reset values of the configuration registers
  localparam logic [30:0] RECORD_LENGTH_RESET  = 31'd2147483639;
  localparam logic [30:0] PARTICLE_COUNT_RESET = 31'd1;

  // Bytes of an end marker plus the next start marker
  localparam logic [3:0] MARKER_PAIR_BYTES = 4'd8;

  // Number of bytes gathered before the last byte of a word
  localparam logic [1:0] LAST_BYTE_PHASE = 2'd3;

  // Coordinate axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [30:0] record_length;
    logic [30:0] particle_count;
  } rmd_cfg_t;

  typedef struct packed {
    logic [31:0] word_bits;
    logic [1:0]  axis;
    logic [30:0] particle_index;
    logic        last_word;
  } rmd_result_t;

endpackage

@@ src/rmd_regs.sv @@
// ----------------------------------------------------------------------------
// rmd_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module rmd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rmd_pkg::rmd_cfg_t            cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.record_length  <= rmd_pkg::RECORD_LENGTH_RESET;
      cfg.particle_count <= rmd_pkg::PARTICLE_COUNT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        rmd_pkg::REG_RECORD_LENGTH:  cfg.record_length  <= pwdata[30:0];
        rmd_pkg::REG_PARTICLE_COUNT: cfg.particle_count <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      rmd_pkg::REG_RECORD_LENGTH:  prdata = {1'b0, cfg.record_length};
      rmd_pkg::REG_PARTICLE_COUNT: prdata = {1'b0, cfg.particle_count};
      default:                     prdata = 32'd0;
    endcase
  end

  logic unused_paddr;
  assign unused_paddr = ^paddr[1:0];

endmodule

@@ src/rmd_frame.sv @@
// ----------------------------------------------------------------------------
// rmd_frame
// Marker skipping, big-endian word packing and axis/particle tracking.
// ----------------------------------------------------------------------------
module rmd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  rmd_pkg::rmd_cfg_t     cfg,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  output logic                  res_valid,
  output rmd_pkg::rmd_result_t  res
);

  logic [30:0] bytes_in_record, bytes_in_record_next;
  logic [3:0]  marker_bytes_left, marker_bytes_left_next;
  logic [23:0] partial_word, partial_word_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [1:0]  current_axis, current_axis_next;
  logic [30:0] current_particle, current_particle_next;

  logic [30:0] count_inc;
  logic [30:0] last_index;
  logic        at_last_particle;
  logic        is_last;

  assign count_inc        = bytes_in_record + 31'd1;
  assign last_index       = cfg.particle_count - 31'd1;
  assign at_last_particle = (current_particle == last_index);
  assign is_last          = (current_axis == rmd_pkg::AXIS_Z) && at_last_particle;

  // Result of the byte being transferred
  always_comb begin
    res.word_bits      = {partial_word, data_byte};
    res.axis           = current_axis;
    res.particle_index = current_particle;
    res.last_word      = is_last;
    res_valid          = accept && (marker_bytes_left == 4'd0) &&
                         (byte_phase == rmd_pkg::LAST_BYTE_PHASE);
  end

  // Next state
  always_comb begin
    bytes_in_record_next   = bytes_in_record;
    marker_bytes_left_next = marker_bytes_left;
    partial_word_next      = partial_word;
    byte_phase_next        = byte_phase;
    current_axis_next      = current_axis;
    current_particle_next  = current_particle;
    if (accept) begin
      if (marker_bytes_left != 4'd0) begin
        // Drop a marker byte
        marker_bytes_left_next = marker_bytes_left - 4'd1;
      end else begin
        // Count data bytes and arm the marker skip at the chunk end
        if (count_inc == cfg.record_length) begin
          bytes_in_record_next   = 31'd0;
          marker_bytes_left_next = rmd_pkg::MARKER_PAIR_BYTES;
        end else begin
          bytes_in_record_next = count_inc;
        end
        if (byte_phase != rmd_pkg::LAST_BYTE_PHASE) begin
          partial_word_next = {partial_word[15:0], data_byte};
          byte_phase_next   = byte_phase + 2'd1;
        end else begin
          partial_word_next = 24'd0;
          byte_phase_next   = 2'd0;
          priority if (is_last) begin
            // Final word: back to the reset state
            bytes_in_record_next   = 31'd0;
            marker_bytes_left_next = 4'd0;
            current_axis_next      = rmd_pkg::AXIS_X;
            current_particle_next  = 31'd0;
          end else if (at_last_particle) begin
            current_particle_next = 31'd0;
            current_axis_next     = current_axis + 2'd1;
          end else begin
            current_particle_next = current_particle + 31'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_record   <= 31'd0;
      marker_bytes_left <= 4'd0;
      partial_word      <= 24'd0;
      byte_phase        <= 2'd0;
      current_axis      <= rmd_pkg::AXIS_X;
      current_particle  <= 31'd0;
    end else begin
      bytes_in_record   <= bytes_in_record_next;
      marker_bytes_left <= marker_bytes_left_next;
      partial_word      <= partial_word_next;
      byte_phase        <= byte_phase_next;
      current_axis      <= current_axis_next;
      current_particle  <= current_particle_next;
    end
  end

endmodule

@@ src/rmd_skid.sv @@
// ----------------------------------------------------------------------------
// rmd_skid
// Output register with one skid entry, so input never waits on a single stall.
// ----------------------------------------------------------------------------
module rmd_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  rmd_pkg::rmd_result_t  res,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rmd_pkg::rmd_result_t  out_res
);

  logic                 skid_valid;
  rmd_pkg::rmd_result_t skid_res;
  logic                 out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  // Control: output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: refill from the skid entry first, else take the new result
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

endmodule

@@ src/record_marker_deframer.sv @@
// ----------------------------------------------------------------------------
// record_marker_deframer
// Strips 8-byte record marker pairs from a sequential record byte stream and
// packs the data bytes into big-endian 32-bit words tagged with axis and
// particle index.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   input    | in_valid / in_stall | data_byte
//   output   | out_valid/out_stall | word_bits, axis, particle_index, last_word
//   config   | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// One byte is taken per cycle while in_stall is low. The word that a fourth
// data byte completes goes to the output register, or to the skid entry while
// the output is stalled. Counters and shift register update on each accepted
// byte. A one-entry skid stage behind the output register keeps in_stall low
// through a single stalled result; it rises only while two results are held.
// Synchronous reset clears all stream state and loads the register defaults;
// the block also returns to that stream state by itself after the final word.
module record_marker_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  word_bits,
  output logic [1:0]                   axis,
  output logic [30:0]                  particle_index,
  output logic                         last_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  rmd_pkg::rmd_cfg_t    cfg;
  rmd_pkg::rmd_result_t res;
  rmd_pkg::rmd_result_t out_res;
  logic                 res_valid;
  logic                 accept;
  logic                 full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  rmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rmd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Split the result onto its ports
  assign word_bits      = out_res.word_bits;
  assign axis           = out_res.axis;
  assign particle_index = out_res.particle_index;
  assign last_word      = out_res.last_word;

endmodule

@@ src/rmd_checker.sv @@
// ----------------------------------------------------------------------------
// rmd_checker
// Port-level checks of the record marker deframer.
// ----------------------------------------------------------------------------
module rmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] word_bits,
  input logic [1:0]  axis,
  input logic [30:0] particle_index,
  input logic        last_word
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_bits) && $stable(axis) &&
      $stable(particle_index) && $stable(last_word))
    else $error("stalled result changed");

  // Input only stalls while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // The final word is always a z word
  a_last_is_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> axis == rmd_pkg::AXIS_Z)
    else $error("last word on wrong axis");

  // Axis code stays in range
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> axis == rmd_pkg::AXIS_X || axis == rmd_pkg::AXIS_Y ||
      axis == rmd_pkg::AXIS_Z)
    else $error("axis out of range");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind record_marker_deframer rmd_checker u_rmd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .word_bits      (word_bits),
  .axis           (axis),
  .particle_index (particle_index),
  .last_word      (last_word)
);

@@ sim/record_marker_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// record_marker_deframer_tb
// Self-checking bench for the record marker deframer. Byte streams are sent
// frame by frame under several record lengths and particle counts, with the
// sender and the receiver idling at random. A model of the deframer predicts
// every word, and each word transfer is checked field by field.
// ----------------------------------------------------------------------------
module record_marker_deframer_tb;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   data_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [31:0]                  word_bits;
  logic [1:0]                   axis;
  logic [30:0]                  particle_index;
  logic                         last_word;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rmd_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  // Deframer model state and configuration
  rmd_pkg::rmd_cfg_t cfg = '{record_length: rmd_pkg::RECORD_LENGTH_RESET,
                             particle_count: rmd_pkg::PARTICLE_COUNT_RESET};
  logic [30:0] chunk_fill = '0;
  logic [3:0]  skip_left = '0;
  logic [23:0] gathered = '0;
  logic [1:0]  gather_count = '0;
  logic [1:0]  axis_now = rmd_pkg::AXIS_X;
  logic [30:0] particle_now = '0;
  logic        frame_done = 1'b0;

  rmd_pkg::rmd_result_t pending_words[$];

  int  fail_count = 0;
  int  sent_bytes = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  record_marker_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_bits      (word_bits),
    .axis           (axis),
    .particle_index (particle_index),
    .last_word      (last_word),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Advance the model by one accepted byte; queue the word it completes
  function automatic void deframe_byte(input logic [7:0] b);
    rmd_pkg::rmd_result_t w;
    logic [30:0] last_idx;
    if (skip_left != 4'd0) begin
      skip_left = skip_left - 4'd1;
      return;
    end
    chunk_fill = chunk_fill + 31'd1;
    if (chunk_fill == cfg.record_length) begin
      chunk_fill = '0;
      skip_left  = rmd_pkg::MARKER_PAIR_BYTES;
    end
    if (gather_count < rmd_pkg::LAST_BYTE_PHASE) begin
      gathered     = {gathered[15:0], b};
      gather_count = gather_count + 2'd1;
      return;
    end
    last_idx         = cfg.particle_count - 31'd1;
    w.word_bits      = {gathered, b};
    w.axis           = axis_now;
    w.particle_index = particle_now;
    w.last_word      = (axis_now == rmd_pkg::AXIS_Z) && (particle_now == last_idx);
    pending_words.push_back(w);
    gathered     = '0;
    gather_count = '0;
    if (w.last_word) begin
      chunk_fill   = '0;
      skip_left    = '0;
      axis_now     = rmd_pkg::AXIS_X;
      particle_now = '0;
      frame_done   = 1'b1;
    end else if (particle_now == last_idx) begin
      particle_now = '0;
      axis_now     = axis_now + 2'd1;
    end else begin
      particle_now = particle_now + 31'd1;
    end
  endfunction

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    sent_bytes++;
  endtask

  // Stop offering and wait for every predicted word, then let markers settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while idle, then read it back
  task automatic set_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == rmd_pkg::REG_RECORD_LENGTH) cfg.record_length = value[30:0];
    else cfg.particle_count = value[30:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == rmd_pkg::REG_RECORD_LENGTH) ? {1'b0, cfg.record_length}
                                               : {1'b0, cfg.particle_count};
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %h, want %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Send random bytes until the model closes the frame; optionally pause
  task automatic send_frame(input int pause_at);
    int count;
    count      = 0;
    frame_done = 1'b0;
    while (!frame_done) begin
      send_byte(8'($urandom_range(255)));
      count++;
      if (pause_at != 0 && count % pause_at == 0 && !frame_done) drain_results();
    end
  endtask

  // Hold the receiver side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare each word transfer with the oldest prediction
  always @(posedge clk) begin
    rmd_pkg::rmd_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", word_bits));
      end else begin
        w = pending_words.pop_front();
        if (word_bits !== w.word_bits)
          report_mismatch($sformatf("word_bits %h, want %h", word_bits, w.word_bits));
        if (axis !== w.axis)
          report_mismatch($sformatf("axis %0d, want %0d", axis, w.axis));
        if (particle_index !== w.particle_index)
          report_mismatch($sformatf("particle_index %0d, want %0d",
                                    particle_index, w.particle_index));
        if (last_word !== w.last_word)
          report_mismatch($sformatf("last_word %b, want %b", last_word, w.last_word));
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset values, then one frame with marker pairs between single words
  task automatic test_directed_frame();
    logic [31:0] words[3];
    words[0] = 32'h0000_0000;
    words[1] = 32'hFFFF_FFFF;
    words[2] = 32'h807F_01FE;
    set_reg(rmd_pkg::REG_RECORD_LENGTH, {1'b0, rmd_pkg::RECORD_LENGTH_RESET});
    set_reg(rmd_pkg::REG_PARTICLE_COUNT, {1'b0, rmd_pkg::PARTICLE_COUNT_RESET});
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'd4);
    frame_done = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 3; i >= 0; i--) send_byte(words[k][8*i +: 8]);
      if (k < 2)
        for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'hA5 : 8'h5A);
    end
  endtask

  // Record lengths below one word: markers fall inside words
  task automatic test_short_records();
    for (int rl = 1; rl <= 3; rl++) begin
      set_reg(rmd_pkg::REG_RECORD_LENGTH, rl);
      set_reg(rmd_pkg::REG_PARTICLE_COUNT, $urandom_range(1, 3));
      send_frame(0);
    end
  endtask

  // Record length zero, the largest value and the reset value
  task automatic test_record_length_extremes();
    set_reg(rmd_pkg::REG_PARTICLE_COUNT, 32'd2);
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'h0000_0000);
    send_frame(0);
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'hFFFF_FFFF);
    send_frame(0);
    set_reg(rmd_pkg::REG_RECORD_LENGTH, {1'b0, rmd_pkg::RECORD_LENGTH_RESET});
    send_frame(0);
  endtask

  // Particle count zero and the largest count; close each frame by lowering
  // the count to just past the current particle
  task automatic test_particle_count_extremes();
    logic [31:0] counts[2];
    counts[0] = 32'h8000_0000;
    counts[1] = 32'hFFFF_FFFF;
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'd9);
    for (int k = 0; k < 2; k++) begin
      set_reg(rmd_pkg::REG_PARTICLE_COUNT, counts[k]);
      frame_done = 1'b0;
      repeat (50) send_byte(8'($urandom_range(255)));
      drain_results();
      set_reg(rmd_pkg::REG_PARTICLE_COUNT, {1'b0, particle_now + 31'd1});
      send_frame(0);
    end
  endtask

  // Long receiver hold-off while bytes keep coming, so the input stalls
  task automatic test_output_holdoff();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'd5);
    set_reg(rmd_pkg::REG_PARTICLE_COUNT, 32'd8);
    hold_toggle <= ~hold_toggle;
    send_frame(0);
  endtask

  // Sender pauses mid-frame until every word has arrived
  task automatic test_sender_pause();
    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'd7);
    set_reg(rmd_pkg::REG_PARTICLE_COUNT, 32'd4);
    send_frame(9);
    send_frame(13);
  endtask

  // Random configurations and content under each idling mode
  task automatic test_random_streams();
    int tx_modes[4];
    int rx_modes[4];
    int target;
    int pick;
    tx_modes = '{0, 85, 0, 31};
    rx_modes = '{0, 0, 85, 31};
    for (int m = 0; m < 4; m++) begin
      tx_idle_pct  = tx_modes[m];
      rx_stall_pct = rx_modes[m];
      target = sent_bytes + 60;
      while (sent_bytes < target) begin
        pick = $urandom_range(9);
        if (pick < 2)
          set_reg(rmd_pkg::REG_RECORD_LENGTH,
                  {1'($urandom_range(1)), 31'($urandom_range(1, 3))});
        else if (pick < 8)
          set_reg(rmd_pkg::REG_RECORD_LENGTH,
                  {1'($urandom_range(1)), 31'($urandom_range(4, 20))});
        else if (pick == 8)
          set_reg(rmd_pkg::REG_RECORD_LENGTH,
                  {1'($urandom_range(1)), 31'($urandom_range(21, 300))});
        else
          set_reg(rmd_pkg::REG_RECORD_LENGTH, 32'd4);
        if ($urandom_range(7) == 0)
          set_reg(rmd_pkg::REG_PARTICLE_COUNT,
                  {1'($urandom_range(1)), 31'($urandom_range(6, 30))});
        else
          set_reg(rmd_pkg::REG_PARTICLE_COUNT,
                  {1'($urandom_range(1)), 31'($urandom_range(1, 5))});
        send_frame(0);
        if ($urandom_range(1)) send_frame(0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frame();
    test_short_records();
    test_record_length_extremes();
    test_particle_count_extremes();
    test_output_holdoff();
    test_sender_pause();
    test_random_streams();
    drain_results();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
src/rmd_pkg.sv
src/rmd_regs.sv
src/rmd_frame.sv
src/rmd_skid.sv
src/record_marker_deframer.sv
src/rmd_checker.sv
sim/record_marker_deframer_tb.sv
